### design/aes_block_cipher_top_defines.svh
// Assertion macros shared by the AES block cipher RTL.
`ifndef AES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES_BLOCK_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes: next-cycle check failed");

`endif

### design/aes_pkg.sv
`default_nettype none

package aes_pkg;

    localparam int MAX_ROUNDS = 14;
    localparam int KEY_ROWS   = MAX_ROUNDS + 1;
    localparam int ROW_W      = $clog2(KEY_ROWS + 1);
    localparam int BLOCK_W    = 128;

    localparam logic [ROW_W-1:0] ROUNDS_128 = ROW_W'(10);
    localparam logic [ROW_W-1:0] ROUNDS_256 = ROW_W'(14);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_IS_256 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PRIME,
        ST_ADD0,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // Control into the key expansion datapath
    typedef struct packed {
        logic             key_is_256;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] rounds;
        logic [7:0]       rcon;
    } exp_ctl_t;

    // Control into the round datapath
    typedef struct packed {
        logic decrypt;
        logic initial_add;
        logic final_round;
    } round_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // MixColumns on one column, byte 0 in the top bits
    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // InvMixColumns on one column; 9, 11, 13, 14 built from x2, x4, x8
    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++)
        begin
            a[i]   = w[31-8*i -: 8];
            x2     = xt(a[i]);
            x4     = xt(x2);
            x8     = xt(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

endpackage

`default_nettype wire

### design/aes_block_cipher_top.sv
// AES block cipher, 128- or 256-bit key.
// Channels: in_valid/in_ready carry a block and a direction (req_type 0 encrypt,
// 1 decrypt); out_valid/out_ready return the result block. Configuration is a
// plain write port (cfg_write, cfg_index, cfg_data): index 0 key size, 1..4 key
// words. Any register write marks the round keys stale.
// The first transfer after reset or a key write first expands the key into two
// round-key RAMs. Each block then runs through its rounds one round per cycle,
// set by the single round unit fed from the key RAMs, whose registered read is
// issued in the cycle before the round that uses it. One block is in work at a
// time; the next block is accepted only once the last result has moved to the
// output register.
// A finished result sits in an output register; the next block is accepted
// while it waits. If the receiver stalls, a second finished block holds in the
// data register until the output register is free.
// Reset clears the key registers, the key size (AES-128) and the schedule-valid
// flag; the round-key RAMs are not cleared, they are always rewritten first.
`default_nettype none

`include "aes_block_cipher_top_defines.svh"

module aes_block_cipher_top #(
    parameter int MAX_ROUNDS = aes_pkg::MAX_ROUNDS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire aes_pkg::in_item_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output aes_pkg::out_item_t                     out_data,
    input  wire logic                              cfg_write,
    input  wire logic [aes_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [63:0]                       cfg_data
);

    import aes_pkg::*;

    localparam int DEPTH = MAX_ROUNDS + 1;

    state_t state_reg, state_next;

    logic             key_is_256_reg;
    logic [63:0]      key0_reg, key1_reg, key2_reg, key3_reg;
    logic             sched_ready_reg;
    logic             dir_reg;
    logic [127:0]     data_reg;
    logic [ROW_W-1:0] rnd_reg;
    logic [ROW_W-1:0] exp_row_reg;
    logic [7:0]       rcon_reg;
    logic [127:0]     prev_reg, prev2_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic [ROW_W-1:0] rounds;
    logic [ROW_W-1:0] step_next;
    logic             accept;
    logic             out_load;
    logic             ram_re;
    logic [ROW_W-1:0] ram_raddr;
    logic             enc_we, dec_we;
    logic [127:0]     enc_rdata, dec_rdata;
    logic [127:0]     enc_row, dec_row;
    logic [7:0]       rcon_next;
    logic [127:0]     round_out;
    exp_ctl_t         exp_ctl;
    round_ctl_t       round_ctl;

    assign rounds    = key_is_256_reg ? ROUNDS_256 : ROUNDS_128;
    assign accept    = in_valid && in_ready;
    assign step_next = rnd_reg + ROW_W'(1);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sched_ready_reg ? ST_ADD0 : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (exp_row_reg == rounds + ROW_W'(1))
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:  state_next = ST_ADD0;
            ST_ADD0:   state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (rnd_reg == rounds)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, key RAM reads and writes, round control
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        enc_we    = 1'b0;
        dec_we    = 1'b0;
        round_ctl = '{decrypt: dir_reg, initial_add: 1'b0, final_round: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ram_re    = in_valid && sched_ready_reg;
                ram_raddr = in_data.req_type ? rounds : '0;
            end
            ST_EXPAND:
            begin
                enc_we = (exp_row_reg <= rounds);
                dec_we = (exp_row_reg != '0);
            end
            ST_PRIME:
            begin
                ram_re    = 1'b1;
                ram_raddr = dir_reg ? rounds : '0;
            end
            ST_ADD0, ST_ROUND:
            begin
                ram_re    = (rnd_reg < rounds);
                ram_raddr = dir_reg ? rounds - step_next : step_next;
                round_ctl.initial_add = (state_reg == ST_ADD0);
                round_ctl.final_round = (rnd_reg == rounds);
            end
            ST_FINISH: ;
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_is_256_reg <= 1'b0;
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KEY_IS_256: key_is_256_reg <= cfg_data[0];
                CFG_KEY_WORD_0: key0_reg <= cfg_data;
                CFG_KEY_WORD_1: key1_reg <= cfg_data;
                CFG_KEY_WORD_2: key2_reg <= cfg_data;
                CFG_KEY_WORD_3: key3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sched_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            rnd_reg         <= '0;
            exp_row_reg     <= '0;
            rcon_reg        <= RCON_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && cfg_index <= CFG_KEY_WORD_3)
            begin
                sched_ready_reg <= 1'b0;
            end
            else if (state_reg == ST_EXPAND && exp_row_reg == rounds + ROW_W'(1))
            begin
                sched_ready_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                exp_row_reg <= '0;
                rcon_reg    <= RCON_INIT;
            end
            else if (state_reg == ST_EXPAND)
            begin
                exp_row_reg <= exp_row_reg + ROW_W'(1);
                if (enc_we)
                begin
                    rcon_reg <= rcon_next;
                end
            end
            if (state_reg == ST_ADD0 || state_reg == ST_ROUND)
            begin
                rnd_reg <= step_next;
            end
            else
            begin
                rnd_reg <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= {in_data.block_hi, in_data.block_lo};
            dir_reg  <= in_data.req_type;
        end
        else if (state_reg == ST_ADD0 || state_reg == ST_ROUND)
        begin
            data_reg <= round_out;
        end
        if (enc_we)
        begin
            prev2_reg <= prev_reg;
            prev_reg  <= enc_row;
        end
        if (out_load)
        begin
            out_data_reg <= '{result_hi: data_reg[127:64], result_lo: data_reg[63:0]};
        end
    end

    assign exp_ctl = '{key_is_256: key_is_256_reg, row: exp_row_reg,
                       rounds: rounds, rcon: rcon_reg};

    aes_key_expand u_key_expand (
        .ctl       (exp_ctl),
        .key       ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .prev      (prev_reg),
        .prev2     (prev2_reg),
        .enc_row   (enc_row),
        .dec_row   (dec_row),
        .rcon_next (rcon_next)
    );

    aes_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (DEPTH)
    ) u_enc_ram (
        .clk   (clk),
        .we    (enc_we),
        .waddr (exp_row_reg),
        .wdata (enc_row),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (enc_rdata)
    );

    aes_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (DEPTH)
    ) u_dec_ram (
        .clk   (clk),
        .we    (dec_we),
        .waddr (exp_row_reg - ROW_W'(1)),
        .wdata (dec_row),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (dec_rdata)
    );

    aes_round u_round (
        .ctl        (round_ctl),
        .state      (data_reg),
        .round_key  (dir_reg ? dec_rdata : enc_rdata),
        .next_state (round_out)
    );

    // Checks
    `AES_ASSERT_NOW(a_busy_no_accept, state_reg != ST_IDLE, !in_ready)
    `AES_ASSERT_NOW(a_keys_valid_in_rounds, state_reg == ST_ADD0, sched_ready_reg)
    `AES_ASSERT_NEXT(a_expand_done, state_reg == ST_EXPAND && exp_row_reg == rounds + ROW_W'(1) && !cfg_write, sched_ready_reg)
    `AES_ASSERT_NOW(a_round_bound, state_reg == ST_ROUND, rnd_reg <= rounds && rnd_reg != '0)
    `AES_ASSERT_NEXT(a_finish_loads, state_reg == ST_FINISH && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE)

endmodule

`default_nettype wire

### design/aes_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/aes_key_expand.sv
`default_nettype none

// One round-key row per cycle, plus the inverse-cipher form of the row before
module aes_key_expand (
    input  wire aes_pkg::exp_ctl_t  ctl,
    input  wire logic [255:0]       key,
    input  wire logic [127:0]       prev,
    input  wire logic [127:0]       prev2,
    output logic      [127:0]       enc_row,
    output logic      [127:0]       dec_row,
    output logic      [7:0]         rcon_next
);

    import aes_pkg::*;

    logic        use_rot;
    logic        from_key;
    logic [31:0] t_word;
    logic [31:0] w0, w1, w2, w3;
    logic [127:0] base;

    // Transform of the last word, then the xor chain across the row
    always_comb
    begin
        from_key = (ctl.row == '0) || (ctl.key_is_256 && ctl.row == ROW_W'(1));
        use_rot  = !ctl.key_is_256 || !ctl.row[0];
        base     = ctl.key_is_256 ? prev2 : prev;
        if (use_rot)
        begin
            t_word = sub_word({prev[23:0], prev[31:24]}) ^ {ctl.rcon, 24'h000000};
        end
        else
        begin
            t_word = sub_word(prev[31:0]);
        end
        w0 = base[127:96] ^ t_word;
        w1 = base[95:64] ^ w0;
        w2 = base[63:32] ^ w1;
        w3 = base[31:0] ^ w2;
        if (ctl.row == '0)
        begin
            enc_row = key[255:128];
        end
        else if (from_key)
        begin
            enc_row = key[127:0];
        end
        else
        begin
            enc_row = {w0, w1, w2, w3};
        end
        rcon_next = (!from_key && use_rot) ? xt(ctl.rcon) : ctl.rcon;
    end

    // Middle rows of the inverse schedule go through InvMixColumns
    always_comb
    begin
        if (ctl.row >= ROW_W'(2) && ctl.row <= ctl.rounds)
        begin
            dec_row = {inv_mix_col(prev[127:96]), inv_mix_col(prev[95:64]),
                       inv_mix_col(prev[63:32]), inv_mix_col(prev[31:0])};
        end
        else
        begin
            dec_row = prev;
        end
    end

endmodule

`default_nettype wire

### design/aes_round.sv
`default_nettype none

// One cipher round (or the initial key addition) on the 128-bit state
module aes_round (
    input  wire aes_pkg::round_ctl_t ctl,
    input  wire logic [127:0]        state,
    input  wire logic [127:0]        round_key,
    output logic      [127:0]        next_state
);

    import aes_pkg::*;

    logic [127:0] shifted;
    logic [127:0] mixed;

    // SubBytes with ShiftRows, or their inverses
    always_comb
    begin
        shifted = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (ctl.decrypt)
                begin
                    shifted[127-8*(((c+r)%4)*4+r) -: 8] = INV_SBOX[state[127-8*(c*4+r) -: 8]];
                end
                else
                begin
                    shifted[127-8*(c*4+r) -: 8] = SBOX[state[127-8*(((c+r)%4)*4+r) -: 8]];
                end
            end
        end
    end

    // Column mixing, skipped in the final round
    always_comb
    begin
        mixed = shifted;
        if (!ctl.final_round)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mixed[127-32*c -: 32] = ctl.decrypt ? inv_mix_col(shifted[127-32*c -: 32])
                                                    : mix_col(shifted[127-32*c -: 32]);
            end
        end
    end

    assign next_state = (ctl.initial_add ? state : mixed) ^ round_key;

endmodule

`default_nettype wire
